@@ sv/recent_id_dedup_counter_core_macros.svh @@
// Assertion helpers for the checker file of this block.
`ifndef RECENT_ID_DEDUP_COUNTER_CORE_MACROS_SVH
`define RECENT_ID_DEDUP_COUNTER_CORE_MACROS_SVH

// Concurrent assertion clocked on clk_i, quiet while rst_ni is low.
`define RDC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

`endif

@@ sv/rdc_pkg.sv @@
package rdc_pkg;

  localparam int unsigned IdWidth    = 32;
  localparam int unsigned CountWidth = 10;
  localparam int unsigned NumKinds   = 3;

  localparam logic [CountWidth-1:0] CountMax = 10'd999;

  // Operation codes of the op field.
  localparam logic OpRecord = 1'b0;
  localparam logic OpClear  = 1'b1;

  // Stat kinds. The last code has no list and no counter.
  localparam logic [1:0] KindZero   = 2'd0;
  localparam logic [1:0] KindOne    = 2'd1;
  localparam logic [1:0] KindTwo    = 2'd2;
  localparam logic [1:0] KindUnused = 2'd3;

  // Card kind at which the counters advance.
  localparam logic [1:0] CountingCard = 2'd2;

  // Configuration register indexes.
  localparam logic CfgStatsEnable = 1'b0;
  localparam logic CfgCardKind    = 1'b1;

  // Per-cycle control handed from the list to each of its cells.
  typedef struct packed {
    logic upd;  // a record transaction targets this list
    logic clr;  // a clear transaction zeroes the list
  } cell_ctrl_t;

endpackage

@@ sv/rdc_cell.sv @@
module rdc_cell (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  rdc_pkg::cell_ctrl_t            ctrl_i,
  input  logic [rdc_pkg::IdWidth-1:0]    id_i,
  input  logic [rdc_pkg::IdWidth-1:0]    prev_i,
  input  logic                           found_i,
  output logic [rdc_pkg::IdWidth-1:0]    data_o,
  output logic                           found_o
);

  logic [rdc_pkg::IdWidth-1:0] data_q, data_d;

  // A cell at or above the first match (or every cell on a miss) takes its
  // upper neighbor's entry; cells below the match keep theirs.
  always_comb begin
    data_d = data_q;
    if (ctrl_i.clr) begin
      data_d = '0;
    end else if (ctrl_i.upd && !found_i) begin
      data_d = prev_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      data_q <= '0;
    end else begin
      data_q <= data_d;
    end
  end

  assign data_o  = data_q;
  assign found_o = found_i | (data_q == id_i);

endmodule

@@ sv/rdc_list.sv @@
module rdc_list #(
  parameter int unsigned Depth = 5
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  rdc_pkg::cell_ctrl_t         ctrl_i,
  input  logic [rdc_pkg::IdWidth-1:0] id_i,
  output logic                        hit_o
);

  logic [rdc_pkg::IdWidth-1:0] data[Depth];
  logic [Depth:0]              found;

  assign found[0] = 1'b0;

  for (genvar i = 0; i < Depth; i++) begin : g_cell
    logic [rdc_pkg::IdWidth-1:0] prev;

    // The front cell takes the new ID; every other cell takes its neighbor.
    if (i == 0) begin : g_front
      assign prev = id_i;
    end else begin : g_rest
      assign prev = data[i-1];
    end

    rdc_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctrl_i  (ctrl_i),
      .id_i    (id_i),
      .prev_i  (prev),
      .found_i (found[i]),
      .data_o  (data[i]),
      .found_o (found[i+1])
    );
  end

  assign hit_o = found[Depth];

endmodule

@@ sv/recent_id_dedup_counter_core.sv @@
// Recent-ID dedup counter. A transaction is taken at any clock edge with
// start high (busy is never raised), one per clock. Its result appears
// on done_o and the result ports in the following cycle, for that cycle only;
// the receiver must take it then. Each list is a row of LIST_DEPTH cells that
// compare the incoming ID and shift together. After reset the lists and
// counters are zero and stats are disabled.
module recent_id_dedup_counter_core #(
  parameter int unsigned LIST_DEPTH = 5
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic        op_i,
  input  logic [1:0]  stat_kind_i,
  input  logic [31:0] partner_id_i,
  output logic        done_o,
  output logic        was_new_o,
  output logic [9:0]  count_kind_zero_o,
  output logic [9:0]  count_kind_one_o,
  output logic [9:0]  count_kind_two_o,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [1:0]  cfg_wdata_i
);

  logic       stats_enable_q, stats_enable_d;
  logic [1:0] card_kind_q, card_kind_d;
  logic       done_q, was_new_q, was_new_d;
  logic [rdc_pkg::CountWidth-1:0] count_q[rdc_pkg::NumKinds];
  logic [rdc_pkg::CountWidth-1:0] count_d[rdc_pkg::NumKinds];

  logic                accept, record, hit0, hit1, hit;
  rdc_pkg::cell_ctrl_t ctrl0, ctrl1;

  assign busy   = 1'b0;
  assign accept = start && !busy;
  // Kind 3 has no list and no counter, so it is ignored like a disabled record.
  assign record = accept && (op_i == rdc_pkg::OpRecord) && stats_enable_q &&
                  (stat_kind_i != rdc_pkg::KindUnused);

  assign ctrl0.upd = record && (stat_kind_i != rdc_pkg::KindTwo);
  assign ctrl0.clr = accept && (op_i == rdc_pkg::OpClear);
  assign ctrl1.upd = record && (stat_kind_i == rdc_pkg::KindTwo);
  assign ctrl1.clr = ctrl0.clr;

  rdc_list #(.Depth(LIST_DEPTH)) u_list0 (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (ctrl0),
    .id_i   (partner_id_i),
    .hit_o  (hit0)
  );

  rdc_list #(.Depth(LIST_DEPTH)) u_list1 (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (ctrl1),
    .id_i   (partner_id_i),
    .hit_o  (hit1)
  );

  assign hit       = (stat_kind_i == rdc_pkg::KindTwo) ? hit1 : hit0;
  assign was_new_d = record && !hit;

  always_comb begin
    for (int k = 0; k < rdc_pkg::NumKinds; k++) begin
      count_d[k] = count_q[k];
      if (ctrl0.clr) begin
        count_d[k] = '0;
      end else if (was_new_d && (card_kind_q == rdc_pkg::CountingCard) &&
                   (stat_kind_i == k[1:0]) && (count_q[k] < rdc_pkg::CountMax)) begin
        count_d[k] = count_q[k] + 1'b1;
      end
    end
  end

  always_comb begin
    stats_enable_d = stats_enable_q;
    card_kind_d    = card_kind_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        rdc_pkg::CfgStatsEnable: stats_enable_d = cfg_wdata_i[0];
        rdc_pkg::CfgCardKind:    card_kind_d    = cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stats_enable_q <= 1'b0;
      card_kind_q    <= 2'd0;
      done_q         <= 1'b0;
      was_new_q      <= 1'b0;
      for (int k = 0; k < rdc_pkg::NumKinds; k++) begin
        count_q[k] <= '0;
      end
    end else begin
      stats_enable_q <= stats_enable_d;
      card_kind_q    <= card_kind_d;
      done_q         <= accept;
      was_new_q      <= was_new_d;
      for (int k = 0; k < rdc_pkg::NumKinds; k++) begin
        count_q[k] <= count_d[k];
      end
    end
  end

  assign done_o            = done_q;
  assign was_new_o         = was_new_q;
  assign count_kind_zero_o = count_q[0];
  assign count_kind_one_o  = count_q[1];
  assign count_kind_two_o  = count_q[2];

endmodule

@@ sv/rdc_checker.sv @@
`include "recent_id_dedup_counter_core_macros.svh"

module rdc_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       start,
  input logic       busy,
  input logic       op_i,
  input logic       done_o,
  input logic       was_new_o,
  input logic [9:0] count_kind_zero_o,
  input logic [9:0] count_kind_one_o,
  input logic [9:0] count_kind_two_o
);

  logic        accepted, clearing;
  logic [29:0] counts;

  assign accepted = start && !busy;
  assign clearing = accepted && (op_i == rdc_pkg::OpClear);
  assign counts   = {count_kind_zero_o, count_kind_one_o, count_kind_two_o};

  `RDC_ASSERT(a_done_follows_accept, accepted |=> done_o, "no result after transaction")
  `RDC_ASSERT(a_no_spurious_done, !accepted |=> !done_o, "result without transaction")
  `RDC_ASSERT(a_clear_zeroes, clearing |=> (!was_new_o && counts == '0), "clear left nonzero result")
  `RDC_ASSERT(a_counts_hold_idle, !accepted |=> $stable(counts), "counter moved while idle")

endmodule

bind recent_id_dedup_counter_core rdc_checker u_rdc_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .start             (start),
  .busy              (busy),
  .op_i              (op_i),
  .done_o            (done_o),
  .was_new_o         (was_new_o),
  .count_kind_zero_o (count_kind_zero_o),
  .count_kind_one_o  (count_kind_one_o),
  .count_kind_two_o  (count_kind_two_o)
);

@@ test/recent_id_dedup_counter_checker.sv @@
`timescale 1ns / 100ps

// Watches the transaction and result channels of the dedup counter, keeps its
// own copy of the recent-ID lists, counters and registers, and compares every
// result with the oldest prediction still waiting.
module recent_id_dedup_counter_checker
  import rdc_pkg::*;
#(
  parameter int unsigned ListDepth = 5
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic                  busy_i,
  input  logic                  op_i,
  input  logic [1:0]            stat_kind_i,
  input  logic [IdWidth-1:0]    partner_id_i,
  input  logic                  done_i,
  input  logic                  was_new_i,
  input  logic [CountWidth-1:0] count_kind_zero_i,
  input  logic [CountWidth-1:0] count_kind_one_i,
  input  logic [CountWidth-1:0] count_kind_two_i,
  input  logic                  cfg_we_i,
  input  logic                  cfg_idx_i,
  input  logic [1:0]            cfg_wdata_i,
  output int                    fail_count_o,
  output int                    pending_o
);

  typedef struct packed {
    logic                                  was_new;
    logic [NumKinds-1:0][CountWidth-1:0]   counts;
  } tally_t;

  // List 0 serves kinds zero and one, list 1 serves kind two; front first.
  logic [IdWidth-1:0]    seen_ids [2][ListDepth];
  logic [CountWidth-1:0] event_count [NumKinds];
  logic                  stats_on;
  logic [1:0]            card_kind;
  tally_t                tallies_due [$];
  int                    fails = 0;

  initial begin
    fail_count_o = 0;
    pending_o    = 0;
  end

  function automatic void wipe_history();
    for (int l = 0; l < 2; l++) begin
      for (int i = 0; i < ListDepth; i++) begin
        seen_ids[l][i] = '0;
      end
    end
    for (int k = 0; k < NumKinds; k++) begin
      event_count[k] = '0;
    end
  endfunction

  // Moves pid to the front of list lst. Returns 1 when pid was not present,
  // in which case the oldest entry falls off the end.
  function automatic logic promote_id(int unsigned lst, logic [IdWidth-1:0] pid);
    int unsigned pos;
    logic        absent;
    pos    = ListDepth - 1;
    absent = 1'b1;
    for (int i = 0; i < ListDepth; i++) begin
      if (absent && seen_ids[lst][i] == pid) begin
        pos    = i;
        absent = 1'b0;
      end
    end
    for (int i = pos; i > 0; i--) begin
      seen_ids[lst][i] = seen_ids[lst][i-1];
    end
    seen_ids[lst][0] = pid;
    return absent;
  endfunction

  function automatic tally_t track_partner_event(logic o, logic [1:0] k,
                                                 logic [IdWidth-1:0] pid);
    tally_t res;
    res.was_new = 1'b0;
    if (o == OpClear) begin
      wipe_history();
    end else if (stats_on && k <= KindTwo) begin
      if (promote_id((k == KindTwo) ? 1 : 0, pid)) begin
        res.was_new = 1'b1;
        if (card_kind == CountingCard && event_count[k] < CountMax) begin
          event_count[k] = event_count[k] + 1'b1;
        end
      end
    end
    for (int i = 0; i < NumKinds; i++) begin
      res.counts[i] = event_count[i];
    end
    return res;
  endfunction

  function automatic void check_field(string what, int unsigned want, int unsigned got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $realtime, what, want, got);
      fails++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    tally_t due;
    if (!rst_ni) begin
      wipe_history();
      stats_on  = 1'b0;
      card_kind = '0;
      tallies_due.delete();
      pending_o <= 0;
    end else begin
      if (done_i === 1'b1) begin
        if (tallies_due.size() == 0) begin
          $display("%0t: result with no transaction waiting, expected none, actual was_new=%0d",
                   $realtime, was_new_i);
          fails++;
        end else begin
          due = tallies_due.pop_front();
          check_field("was_new", due.was_new, was_new_i);
          check_field("count_kind_zero", due.counts[0], count_kind_zero_i);
          check_field("count_kind_one", due.counts[1], count_kind_one_i);
          check_field("count_kind_two", due.counts[2], count_kind_two_i);
        end
      end
      if (start_i && !busy_i) begin
        tallies_due.push_back(track_partner_event(op_i, stat_kind_i, partner_id_i));
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CfgStatsEnable: stats_on  = cfg_wdata_i[0];
          CfgCardKind:    card_kind = cfg_wdata_i;
          default: ;
        endcase
      end
      pending_o    <= tallies_due.size();
      fail_count_o <= fails;
    end
  end

endmodule

@@ test/recent_id_dedup_counter_core_tb.sv @@
`timescale 1ns / 100ps

module recent_id_dedup_counter_core_tb;
  import rdc_pkg::*;

  localparam int unsigned ListDepth  = 5;
  localparam int          CycleLimit = 200_000;
  localparam int          NumPhases  = 7;

  logic                  clk_i;
  logic                  rst_ni = 1'b0;
  logic                  start = 1'b0;
  logic                  busy;
  logic                  op = OpRecord;
  logic [1:0]            stat_kind = KindZero;
  logic [IdWidth-1:0]    partner_id = '0;
  logic                  done;
  logic                  was_new;
  logic [CountWidth-1:0] count_zero;
  logic [CountWidth-1:0] count_one;
  logic [CountWidth-1:0] count_two;
  logic                  cfg_we = 1'b0;
  logic                  cfg_idx = CfgStatsEnable;
  logic [1:0]            cfg_wdata = '0;
  int                    fail_count;
  int                    pending;
  int                    cycle_count = 0;
  int                    burst_left = 0;
  int                    sent = 0;
  int                    clears = 0;
  int                    settings_used = 0;

  recent_id_dedup_counter_core #(
    .LIST_DEPTH(ListDepth)
  ) dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start            (start),
    .busy             (busy),
    .op_i             (op),
    .stat_kind_i      (stat_kind),
    .partner_id_i     (partner_id),
    .done_o           (done),
    .was_new_o        (was_new),
    .count_kind_zero_o(count_zero),
    .count_kind_one_o (count_one),
    .count_kind_two_o (count_two),
    .cfg_we_i         (cfg_we),
    .cfg_idx_i        (cfg_idx),
    .cfg_wdata_i      (cfg_wdata)
  );

  recent_id_dedup_counter_checker #(
    .ListDepth(ListDepth)
  ) checker_inst (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start_i          (start),
    .busy_i           (busy),
    .op_i             (op),
    .stat_kind_i      (stat_kind),
    .partner_id_i     (partner_id),
    .done_i           (done),
    .was_new_i        (was_new),
    .count_kind_zero_i(count_zero),
    .count_kind_one_i (count_one),
    .count_kind_two_i (count_two),
    .cfg_we_i         (cfg_we),
    .cfg_idx_i        (cfg_idx),
    .cfg_wdata_i      (cfg_wdata),
    .fail_count_o     (fail_count),
    .pending_o        (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("Timeout after %0d cycles with %0d results outstanding", cycle_count, pending);
      $display("Some tests failed");
      $finish;
    end
  end

  // The sender works in bursts; start drops low between bursts.
  // Within a burst start stays high from one transaction to the next.
  task automatic send_event(input logic o, input logic [1:0] k, input logic [IdWidth-1:0] pid);
    if (burst_left == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 7) == 0) ? 60 : $urandom_range(1, 24);
    end
    burst_left--;
    start      <= 1'b1;
    op         <= o;
    stat_kind  <= k;
    partner_id <= pid;
    do @(posedge clk_i); while (busy !== 1'b0);
    sent++;
    if (o == OpClear) clears++;
  endtask

  task automatic wait_idle();
    start <= 1'b0;
    burst_left = 0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  task automatic set_config(input logic en, input logic [1:0] card);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_idx   <= CfgStatsEnable;
    cfg_wdata <= {1'b0, en};
    @(posedge clk_i);
    cfg_idx   <= CfgCardKind;
    cfg_wdata <= card;
    @(posedge clk_i);
    cfg_we    <= 1'b0;
    settings_used++;
  endtask

  initial begin
    logic [IdWidth-1:0] id_pool [8];
    logic [1:0]         phase_card [NumPhases];
    logic               phase_en [NumPhases];
    logic               o;
    logic [1:0]         k;
    logic [IdWidth-1:0] pid;
    int                 pick;

    phase_en   = '{1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1};
    phase_card = '{2'd2, 2'd0, 2'd2, 2'd1, 2'd3, 2'd0, 2'd2};

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Stats are off after reset, so this record must not register.
    send_event(OpRecord, KindZero, 32'hFFFF_FFFF);

    set_config(1'b1, 2'd0);
    send_event(OpRecord, KindZero, 32'h0000_0000);  // hits an empty slot
    send_event(OpRecord, KindZero, 32'hFFFF_FFFF);
    send_event(OpRecord, KindOne, 32'hFFFF_FFFF);   // kinds zero and one share a list
    send_event(OpRecord, KindTwo, 32'hFFFF_FFFF);
    send_event(OpRecord, KindUnused, 32'h0000_1234);

    set_config(1'b1, CountingCard);
    for (int i = 1; i <= 5; i++) begin
      send_event(OpRecord, KindZero, i);
    end
    send_event(OpRecord, KindZero, 32'd1);          // oldest entry, moves to the front
    send_event(OpRecord, KindZero, 32'hFFFF_FFFF);  // evicted earlier, new again
    send_event(OpRecord, KindOne, 32'hA5A5_A5A5);
    send_event(OpRecord, KindTwo, 32'h5A5A_5A5A);
    send_event(OpRecord, KindTwo, 32'h5A5A_5A5A);
    send_event(OpRecord, KindUnused, 32'hFFFF_FFFF);
    send_event(OpClear, KindZero, 32'h0);
    send_event(OpRecord, KindTwo, 32'h5A5A_5A5A);

    set_config(1'b0, 2'd3);
    send_event(OpClear, KindTwo, 32'hFFFF_FFFF);    // clear acts with stats off
    send_event(OpRecord, KindOne, 32'h0000_0077);

    // Distinct IDs for kind zero drive its counter into saturation.
    set_config(1'b1, CountingCard);
    for (int i = 0; i < 1002; i++) begin
      send_event(OpRecord, KindZero, 32'h1000_0000 + i);
    end

    for (int p = 0; p < NumPhases; p++) begin
      set_config(phase_en[p], phase_card[p]);
      // A pool larger than the list gives both hits and misses.
      for (int i = 0; i < 8; i++) begin
        id_pool[i] = $urandom;
      end
      id_pool[0] = '0;
      for (int n = 0; n < 4; n++) begin
        o = ($urandom_range(0, 99) < 3) ? OpClear : OpRecord;
        pick = $urandom_range(0, 9);
        k = (pick < 3) ? KindZero : (pick < 6) ? KindOne : (pick < 9) ? KindTwo : KindUnused;
        pick = $urandom_range(0, 9);
        if (pick < 6) begin
          pid = id_pool[$urandom_range(0, 7)];
        end else if (pick < 9) begin
          pid = $urandom;
        end else begin
          pid = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
        end
        send_event(o, k, pid);
      end
    end

    wait_idle();
    repeat (4) @(posedge clk_i);
    $display("Ran %0d transactions, %0d of them clears, over %0d register settings;",
             sent, clears, settings_used);
    $display("the run included a kind-zero counter saturation sweep.");
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

@@ recent_id_dedup_counter_core.f @@
+incdir+sv
sv/rdc_pkg.sv
sv/rdc_cell.sv
sv/rdc_list.sv
sv/recent_id_dedup_counter_core.sv
sv/rdc_checker.sv
test/recent_id_dedup_counter_checker.sv
test/recent_id_dedup_counter_core_tb.sv
